>>> hdl/atb_pkg.sv
// ----------------------------------------------------------------------------
// atb_pkg
// types, constants and the shared divider word for the alias table builder
// ----------------------------------------------------------------------------
package atb_pkg;

    localparam int MaxEntries = 1024;
    localparam int IdxBits    = 10;
    localparam int CntBits    = 11;
    localparam int WBits      = 16;
    localparam int SumBits    = 26;
    localparam int ResBits    = 27;
    localparam int ProdBits   = 27;
    localparam int AliasBits  = 28;

    localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;
    localparam logic [16:0] OneQ16 = 17'h10000;

    localparam logic ActLoad = 1'b0;
    localparam logic ActRead = 1'b1;

    typedef struct packed {
        logic             action;
        logic [WBits-1:0] weight;
        logic             last;
        logic [IdxBits-1:0] index;
    } in_word_t;

    typedef struct packed {
        logic [IdxBits-1:0] alias_index;
        logic               has_alias;
        logic [16:0]        pick_first_prob;
        logic [31:0]        scale_first;
        logic [31:0]        scale_second;
        logic [31:0]        offset_second;
        logic [SumBits-1:0] total_weight;
    } out_word_t;

    // divider request / reply
    typedef struct packed {
        logic                start;
        logic [ResBits-1:0]  num;
        logic [ProdBits-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } div_rsp_t;

endpackage

>>> hdl/alias_table_builder_core.sv
// ----------------------------------------------------------------------------
// alias_table_builder_core
// builds a vose alias table over loaded weights, serves table reads
// ----------------------------------------------------------------------------
// load: busy stays low unless last is set
// build after last: each entry is classified into the small or large stack, then
//   per pair four divisions run on the shared divider, one division per leftover
// read: start -> S_RD -> rv_reg raises the result strobe; busy until back in idle
// reset clears control state only; tables are undefined until first built
module alias_table_builder_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  atb_pkg::in_word_t  in_word,
    output logic               result_valid,
    output atb_pkg::out_word_t result
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_RD     = 14'b00000000000010,
        S_INIT   = 14'b00000000000100,
        S_INITW  = 14'b00000000001000,
        S_PAIR   = 14'b00000000010000,
        S_PAIRS  = 14'b00000000100000,
        S_PAIRW  = 14'b00000001000000,
        S_PAIRR  = 14'b00000010000000,
        S_DIV    = 14'b00000100000000,
        S_DIVW   = 14'b00001000000000,
        S_PUT    = 14'b00010000000000,
        S_REST   = 14'b00100000000000,
        S_RESTW  = 14'b01000000000000,
        S_RESTD  = 14'b10000000000000
    } state_t;

    localparam int IB = atb_pkg::IdxBits;
    localparam int CB = atb_pkg::CntBits;

    state_t state_reg, state_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic [atb_pkg::SumBits-1:0] sum_reg, sum_next;
    logic done_reg, done_next;
    logic [CB-1:0] stop_reg, stop_next;   // small stack top
    logic [CB-1:0] ltop_reg, ltop_next;   // large stack top
    logic [CB-1:0] i_reg, i_next;
    logic [1:0] ph_reg, ph_next;
    logic [1:0] dsel_reg, dsel_next;
    logic [IB-1:0] sm_reg, sm_next, lg_reg, lg_next;
    logic [atb_pkg::ResBits-1:0] rs_reg, rs_next, red_reg, red_next;
    logic [atb_pkg::WBits-1:0] wsm_reg, wsm_next, wlg_reg, wlg_next;
    logic [31:0] q0_reg, q0_next, q1_reg, q1_next, q2_reg, q2_next;
    logic nores_reg, nores_next;
    logic rv_reg, rv_next;
    logic [IB-1:0] ridx_reg, ridx_next;
    logic rok_reg, rok_next;

    // memory ports
    logic w_we, r_we, s_we, l_we, a_we, sc_we, o_we;
    logic [IB-1:0] w_ad, r_ad, s_ad, l_ad, a_ad;
    logic [atb_pkg::WBits-1:0] w_wd, w_rd;
    logic [atb_pkg::ResBits-1:0] r_wd, r_rd;
    logic [IB-1:0] s_wd, s_rd, l_wd, l_rd;
    logic [atb_pkg::AliasBits-1:0] a_wd, a_rd;
    logic [63:0] sc_wd, sc_rd;
    logic [31:0] o_wd, o_rd;

    atb_ram #(.Width(atb_pkg::WBits), .Depth(atb_pkg::MaxEntries)) u_w (
        .clk(clk), .we(w_we), .addr(w_ad), .wdata(w_wd), .rdata(w_rd));
    atb_ram #(.Width(atb_pkg::ResBits), .Depth(atb_pkg::MaxEntries)) u_r (
        .clk(clk), .we(r_we), .addr(r_ad), .wdata(r_wd), .rdata(r_rd));
    atb_ram #(.Width(IB), .Depth(atb_pkg::MaxEntries)) u_s (
        .clk(clk), .we(s_we), .addr(s_ad), .wdata(s_wd), .rdata(s_rd));
    atb_ram #(.Width(IB), .Depth(atb_pkg::MaxEntries)) u_l (
        .clk(clk), .we(l_we), .addr(l_ad), .wdata(l_wd), .rdata(l_rd));
    atb_ram #(.Width(atb_pkg::AliasBits), .Depth(atb_pkg::MaxEntries)) u_a (
        .clk(clk), .we(a_we), .addr(a_ad), .wdata(a_wd), .rdata(a_rd));
    atb_ram #(.Width(64), .Depth(atb_pkg::MaxEntries)) u_sc (
        .clk(clk), .we(sc_we), .addr(a_ad), .wdata(sc_wd), .rdata(sc_rd));
    atb_ram #(.Width(32), .Depth(atb_pkg::MaxEntries)) u_o (
        .clk(clk), .we(o_we), .addr(a_ad), .wdata(o_wd), .rdata(o_rd));

    atb_pkg::div_req_t dreq;
    atb_pkg::div_rsp_t drsp;

    atb_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [atb_pkg::ProdBits-1:0] n_w;     // N * selected weight
    logic [atb_pkg::WBits-1:0] wmul;
    logic [atb_pkg::ResBits-1:0] red_calc;
    logic [atb_pkg::ResBits-1:0] s_ext;
    logic accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign s_ext  = atb_pkg::ResBits'(sum_reg);
    assign n_w    = atb_pkg::ProdBits'(cnt_reg) * atb_pkg::ProdBits'(wmul);
    assign red_calc = r_rd + rs_reg - s_ext;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;  sum_next = sum_reg;  done_next = done_reg;
        stop_next = stop_reg; ltop_next = ltop_reg; i_next = i_reg;
        ph_next = ph_reg; dsel_next = dsel_reg;
        sm_next = sm_reg; lg_next = lg_reg; rs_next = rs_reg; red_next = red_reg;
        wsm_next = wsm_reg; wlg_next = wlg_reg;
        q0_next = q0_reg; q1_next = q1_reg; q2_next = q2_reg;
        nores_next = nores_reg;
        rv_next = 1'b0; ridx_next = ridx_reg; rok_next = rok_reg;
        w_we = 1'b0; r_we = 1'b0; s_we = 1'b0; l_we = 1'b0;
        a_we = 1'b0; sc_we = 1'b0; o_we = 1'b0;
        w_ad = i_reg[IB-1:0]; r_ad = i_reg[IB-1:0];
        s_ad = '0; l_ad = '0; a_ad = ridx_reg;
        w_wd = in_word.weight; r_wd = '0; s_wd = '0; l_wd = '0;
        a_wd = '0; sc_wd = '0; o_wd = '0;
        dreq = '0;
        wmul = wsm_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_word.action == atb_pkg::ActRead)
                    begin
                        a_ad = in_word.index;
                        ridx_next = in_word.index;
                        rok_next = 1'b1;
                        state_next = S_RD;
                    end
                    else
                    begin
                        logic [CB-1:0] c;
                        logic [atb_pkg::SumBits-1:0] sm;
                        c  = done_reg ? '0 : cnt_reg;
                        sm = done_reg ? '0 : sum_reg;
                        done_next = 1'b0;
                        if (c < CB'(atb_pkg::MaxEntries))
                        begin
                            w_we = 1'b1;
                            w_ad = c[IB-1:0];
                            c = c + CB'(1);
                            sm = sm + atb_pkg::SumBits'(in_word.weight);
                        end
                        cnt_next = c;
                        sum_next = sm;
                        if (in_word.last)
                        begin
                            done_next = 1'b1;
                            i_next = '0; stop_next = '0; ltop_next = '0; ph_next = '0;
                            state_next = S_INIT;
                        end
                    end
                end
            end
            S_RD:
            begin
                rv_next = 1'b1;
                state_next = S_IDLE;
            end
            // classify: read weight, write residual, push index
            S_INIT:
            begin
                if (i_reg == cnt_reg)
                    state_next = S_PAIR;
                else
                begin
                    w_ad = i_reg[IB-1:0];
                    state_next = S_INITW;
                end
            end
            S_INITW:
            begin
                logic [atb_pkg::ResBits-1:0] rr;
                wmul = w_rd;
                rr = atb_pkg::ResBits'(n_w);
                r_we = 1'b1; r_wd = rr;
                if (rr <= s_ext)
                begin
                    s_we = 1'b1; s_ad = stop_reg[IB-1:0]; s_wd = i_reg[IB-1:0];
                    stop_next = stop_reg + CB'(1);
                end
                else
                begin
                    l_we = 1'b1; l_ad = ltop_reg[IB-1:0]; l_wd = i_reg[IB-1:0];
                    ltop_next = ltop_reg + CB'(1);
                end
                i_next = i_reg + CB'(1);
                state_next = S_INIT;
            end
            S_PAIR:
            begin
                if (stop_reg != '0 && ltop_reg != '0)
                begin
                    s_ad = stop_reg[IB-1:0] - IB'(1);
                    l_ad = ltop_reg[IB-1:0] - IB'(1);
                    stop_next = stop_reg - CB'(1);
                    state_next = S_PAIRS;
                end
                else
                    state_next = S_REST;
            end
            S_PAIRS:
            begin
                sm_next = s_rd; lg_next = l_rd;
                w_ad = s_rd; r_ad = s_rd;
                state_next = S_PAIRW;
            end
            S_PAIRW:
            begin
                wsm_next = w_rd; rs_next = r_rd;
                w_ad = lg_reg; r_ad = lg_reg;
                state_next = S_PAIRR;
            end
            S_PAIRR:
            begin
                wlg_next = w_rd;
                red_next = red_calc;
                r_we = 1'b1; r_ad = lg_reg; r_wd = red_calc;
                if (red_calc <= s_ext)
                begin
                    ltop_next = ltop_reg - CB'(1);
                    s_we = 1'b1; s_ad = stop_reg[IB-1:0]; s_wd = lg_reg;
                    stop_next = stop_reg + CB'(1);
                end
                dsel_next = '0;
                nores_next = 1'b0;
                state_next = S_DIV;
            end
            // four quotients on the shared divider
            S_DIV:
            begin
                dreq.start = 1'b1;
                unique case (dsel_reg)
                    2'd0:
                    begin
                        dreq.num = rs_reg; dreq.den = atb_pkg::ProdBits'(s_ext);
                    end
                    2'd1:
                    begin
                        wmul = wsm_reg;
                        dreq.num = s_ext; dreq.den = n_w;
                    end
                    2'd2:
                    begin
                        wmul = wlg_reg;
                        dreq.num = s_ext; dreq.den = n_w;
                    end
                    default:
                    begin
                        wmul = wlg_reg;
                        dreq.num = red_reg - rs_reg; dreq.den = n_w;
                    end
                endcase
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (drsp.done)
                begin
                    unique case (dsel_reg)
                        2'd0: q0_next = drsp.quo;
                        2'd1: q1_next = drsp.quo;
                        2'd2: q2_next = drsp.quo;
                        default: ;
                    endcase
                    if (nores_reg)
                    begin
                        a_we = 1'b1; sc_we = 1'b1; o_we = 1'b1; a_ad = sm_reg;
                        a_wd = {atb_pkg::OneQ16, 1'b0, IB'(0)};
                        sc_wd = {32'd0, drsp.quo};
                        o_wd = '0;
                        state_next = S_REST;
                    end
                    else if (dsel_reg == 2'd3)
                        state_next = S_PUT;
                    else
                    begin
                        dsel_next = dsel_reg + 2'd1;
                        state_next = S_DIV;
                    end
                end
            end
            S_PUT:
            begin
                a_we = 1'b1; sc_we = 1'b1; o_we = 1'b1; a_ad = sm_reg;
                a_wd = {q0_reg[16:0], 1'b1, lg_reg};
                sc_wd = {q2_reg, q1_reg};
                o_wd = drsp.quo;
                state_next = S_PAIR;
            end
            // leftovers get probability one
            S_REST:
            begin
                if (stop_reg != '0)
                begin
                    s_ad = stop_reg[IB-1:0] - IB'(1);
                    stop_next = stop_reg - CB'(1);
                    ph_next = 2'd0;
                    state_next = S_RESTW;
                end
                else if (ltop_reg != '0)
                begin
                    l_ad = ltop_reg[IB-1:0] - IB'(1);
                    ltop_next = ltop_reg - CB'(1);
                    ph_next = 2'd1;
                    state_next = S_RESTW;
                end
                else
                    state_next = S_IDLE;
            end
            S_RESTW:
            begin
                sm_next = (ph_reg == 2'd0) ? s_rd : l_rd;
                w_ad = (ph_reg == 2'd0) ? s_rd : l_rd;
                state_next = S_RESTD;
            end
            S_RESTD:
            begin
                wsm_next = w_rd;
                wmul = w_rd;
                dreq.start = 1'b1; dreq.num = s_ext; dreq.den = n_w;
                dsel_next = 2'd1;
                nores_next = 1'b1;
                state_next = S_DIVW;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0; sum_reg <= '0; done_reg <= 1'b0;
            stop_reg <= '0; ltop_reg <= '0; i_reg <= '0;
            ph_reg <= '0; dsel_reg <= '0; nores_reg <= 1'b0;
            rv_reg <= 1'b0; rok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next; sum_reg <= sum_next; done_reg <= done_next;
            stop_reg <= stop_next; ltop_reg <= ltop_next; i_reg <= i_next;
            ph_reg <= ph_next; dsel_reg <= dsel_next; nores_reg <= nores_next;
            rv_reg <= rv_next; rok_reg <= rok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sm_reg <= sm_next; lg_reg <= lg_next; rs_reg <= rs_next; red_reg <= red_next;
        wsm_reg <= wsm_next; wlg_reg <= wlg_next;
        q0_reg <= q0_next; q1_reg <= q1_next; q2_reg <= q2_next;
        ridx_reg <= ridx_next;
    end

    // output word from registered ram data
    logic [atb_pkg::AliasBits-1:0] a_hold_reg;
    logic [63:0] sc_hold_reg;
    logic [31:0] o_hold_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
        begin
            a_hold_reg <= a_rd; sc_hold_reg <= sc_rd; o_hold_reg <= o_rd;
        end
    end

    assign result_valid = rv_reg && rok_reg;
    assign result.alias_index     = a_hold_reg[IB-1:0];
    assign result.has_alias       = a_hold_reg[IB];
    assign result.pick_first_prob = a_hold_reg[atb_pkg::AliasBits-1:IB+1];
    assign result.scale_first     = sc_hold_reg[31:0];
    assign result.scale_second    = sc_hold_reg[63:32];
    assign result.offset_second   = o_hold_reg;
    assign result.total_weight    = sum_reg;

endmodule

>>> hdl/atb_ram.sv
// ----------------------------------------------------------------------------
// atb_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module atb_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> hdl/atb_div.sv
// ----------------------------------------------------------------------------
// atb_div
// radix-2 restoring divider: floor(num*65536/den) saturated to 32 bits
// ----------------------------------------------------------------------------
module atb_div (
    input  logic              clk,
    input  logic              rst_n,
    input  atb_pkg::div_req_t req,
    output atb_pkg::div_rsp_t rsp
);

    localparam int QBits = atb_pkg::ResBits + 16;

    logic [QBits-1:0]             dvd_reg, dvd_next;
    logic [atb_pkg::ProdBits:0]   rem_reg, rem_next;
    logic [atb_pkg::ProdBits-1:0] den_reg, den_next;
    logic [5:0]                   cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [atb_pkg::ProdBits:0]   trial;
    logic [atb_pkg::ProdBits:0]   shifted;

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[atb_pkg::ProdBits-1:0], dvd_reg[QBits-1]};
        trial     = shifted - {1'b0, den_reg};
        if (req.start)
        begin
            dvd_next  = {req.num, 16'd0};
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 6'(QBits);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[atb_pkg::ProdBits])
            begin
                rem_next = trial;
                dvd_next = {dvd_reg[QBits-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                dvd_next = {dvd_reg[QBits-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = (den_reg == '0 || dvd_reg[QBits-1:32] != '0) ? atb_pkg::Sat32
                                                                    : dvd_reg[31:0];

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks alias_table_builder_core: weight sets are loaded and the built
// table is read back. Each read word is compared with a software build of
// the same table. A directed table comes first, then one oversized set,
// then random sets with reads mixed in, under varying sender gaps.
// ----------------------------------------------------------------------------
module testbench;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    atb_pkg::in_word_t  in_word;
    logic               result_valid;
    atb_pkg::out_word_t result;

    alias_table_builder_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in_word      (in_word),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // table model state
    logic [atb_pkg::WBits-1:0]   wt_mem [atb_pkg::MaxEntries];
    longint unsigned             res_mem [atb_pkg::MaxEntries];
    int                          small_stk [atb_pkg::MaxEntries];
    int                          large_stk [atb_pkg::MaxEntries];
    logic [atb_pkg::IdxBits-1:0] ent_alias [atb_pkg::MaxEntries];
    logic                        ent_has [atb_pkg::MaxEntries];
    logic [16:0]                 ent_prob [atb_pkg::MaxEntries];
    logic [31:0]                 ent_sf [atb_pkg::MaxEntries];
    logic [31:0]                 ent_ss [atb_pkg::MaxEntries];
    logic [31:0]                 ent_os [atb_pkg::MaxEntries];
    int                          set_count;
    longint unsigned             set_sum;
    bit                          set_closed;
    int                          built_count;

    atb_pkg::out_word_t read_words_due[$];
    int                 errors;
    int                 sent_items;
    int                 gap_pct;

    function automatic longint unsigned q16_quot(longint unsigned num,
                                                 longint unsigned den);
        longint unsigned q;
        if (den == 0)
            return atb_pkg::Sat32;
        q = num / den;
        if (q > 64'hFFFF)
            return atb_pkg::Sat32;
        return (q << 16) | (((num % den) << 16) / den);
    endfunction

    function automatic void store_entry(int e, bit has, int al, longint unsigned prob,
                                        longint unsigned sf, longint unsigned ss,
                                        longint unsigned os);
        ent_alias[e] = has ? al[atb_pkg::IdxBits-1:0] : '0;
        ent_has[e]   = has;
        ent_prob[e]  = prob[16:0];
        ent_sf[e]    = sf[31:0];
        ent_ss[e]    = ss[31:0];
        ent_os[e]    = os[31:0];
    endfunction

    function automatic void build_alias_table();
        longint unsigned n;
        longint unsigned s;
        longint unsigned rs;
        longint unsigned red;
        longint unsigned dl;
        int st;
        int lt;
        int sm;
        int lg;
        int e;
        n = set_count;
        s = set_sum;
        st = 0;
        lt = 0;
        for (int i = 0; i < set_count; i++)
        begin
            res_mem[i] = longint'(wt_mem[i]) * n;
            if (res_mem[i] <= s)
            begin
                small_stk[st] = i;
                st = st + 1;
            end
            else
            begin
                large_stk[lt] = i;
                lt = lt + 1;
            end
        end
        while (st > 0 && lt > 0)
        begin
            st = st - 1;
            sm = small_stk[st];
            lg = large_stk[lt-1];
            rs = res_mem[sm];
            red = res_mem[lg] + rs - s;
            dl = n * wt_mem[lg];
            res_mem[lg] = red;
            if (red <= s)
            begin
                lt = lt - 1;
                small_stk[st] = lg;
                st = st + 1;
            end
            store_entry(sm, 1'b1, lg, q16_quot(rs, s), q16_quot(s, n * wt_mem[sm]),
                        q16_quot(s, dl), q16_quot(red - rs, dl));
        end
        while (st > 0 || lt > 0)
        begin
            if (st > 0)
            begin
                st = st - 1;
                e = small_stk[st];
            end
            else
            begin
                lt = lt - 1;
                e = large_stk[lt];
            end
            store_entry(e, 1'b0, 0, atb_pkg::OneQ16, q16_quot(s, n * wt_mem[e]), 0, 0);
        end
        built_count = set_count;
    endfunction

    // advance the model by one accepted word; returns the read word it expects
    function automatic atb_pkg::out_word_t table_step(atb_pkg::in_word_t w);
        atb_pkg::out_word_t r;
        r = '0;
        if (w.action == atb_pkg::ActLoad)
        begin
            if (set_closed)
            begin
                set_count = 0;
                set_sum = 0;
                set_closed = 1'b0;
            end
            if (set_count < atb_pkg::MaxEntries)
            begin
                wt_mem[set_count] = w.weight;
                set_sum += w.weight;
                set_count++;
            end
            if (w.last)
            begin
                build_alias_table();
                set_closed = 1'b1;
            end
        end
        else
        begin
            r.alias_index     = ent_alias[w.index];
            r.has_alias       = ent_has[w.index];
            r.pick_first_prob = ent_prob[w.index];
            r.scale_first     = ent_sf[w.index];
            r.scale_second    = ent_ss[w.index];
            r.offset_second   = ent_os[w.index];
            r.total_weight    = set_sum[atb_pkg::SumBits-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        errors++;
        $display("%0t: %s got %0h want %0h", $time, field, got, want);
    endtask

    always @(posedge clk)
    begin
        atb_pkg::out_word_t want;
        if (rst_n && result_valid)
        begin
            if (read_words_due.size() == 0)
                report_mismatch("unexpected result word", 1, 0);
            else
            begin
                want = read_words_due.pop_front();
                if (result.alias_index !== want.alias_index)
                    report_mismatch("alias_index", result.alias_index, want.alias_index);
                if (result.has_alias !== want.has_alias)
                    report_mismatch("has_alias", result.has_alias, want.has_alias);
                if (result.pick_first_prob !== want.pick_first_prob)
                    report_mismatch("pick_first_prob", result.pick_first_prob,
                                    want.pick_first_prob);
                if (result.scale_first !== want.scale_first)
                    report_mismatch("scale_first", result.scale_first, want.scale_first);
                if (result.scale_second !== want.scale_second)
                    report_mismatch("scale_second", result.scale_second, want.scale_second);
                if (result.offset_second !== want.offset_second)
                    report_mismatch("offset_second", result.offset_second,
                                    want.offset_second);
                if (result.total_weight !== want.total_weight)
                    report_mismatch("total_weight", result.total_weight, want.total_weight);
            end
        end
    end

    // drive one word, wait for acceptance, then maybe leave idle cycles
    task automatic send_word(atb_pkg::in_word_t w, bit typed, atb_pkg::out_word_t typed_want);
        atb_pkg::out_word_t want;
        start   <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        want = table_step(w);
        if (w.action == atb_pkg::ActRead)
            read_words_due.insert(read_words_due.size(), typed ? typed_want : want);
        sent_items++;
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic atb_pkg::in_word_t load_word(logic [atb_pkg::WBits-1:0] wgt,
                                                    logic lst);
        atb_pkg::in_word_t w;
        w.action = atb_pkg::ActLoad;
        w.weight = wgt;
        w.last   = lst;
        w.index  = atb_pkg::IdxBits'($urandom);
        return w;
    endfunction

    function automatic atb_pkg::in_word_t read_word(int idx);
        atb_pkg::in_word_t w;
        w.action = atb_pkg::ActRead;
        w.weight = atb_pkg::WBits'($urandom);
        w.last   = 1'($urandom);
        w.index  = idx[atb_pkg::IdxBits-1:0];
        return w;
    endfunction

    function automatic atb_pkg::out_word_t lone_entry(logic [31:0] sf, int total);
        atb_pkg::out_word_t r;
        r = '0;
        r.pick_first_prob = atb_pkg::OneQ16;
        r.scale_first     = sf;
        r.total_weight    = total[atb_pkg::SumBits-1:0];
        return r;
    endfunction

    function automatic logic [atb_pkg::WBits-1:0] pick_weight();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return atb_pkg::WBits'($urandom_range(1, 8));
            default: return atb_pkg::WBits'($urandom);
        endcase
    endfunction

    typedef struct {
        atb_pkg::in_word_t  w;
        bit                 typed;
        atb_pkg::out_word_t want;
    } stim_row_t;

    stim_row_t dir_rows[$];

    task automatic add_row(atb_pkg::in_word_t w, bit typed = 1'b0,
                           atb_pkg::out_word_t want = '0);
        stim_row_t row;
        row.w = w;
        row.typed = typed;
        row.want = want;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    initial
    begin
        int n;
        int idx;
        errors = 0;
        sent_items = 0;
        set_count = 0;
        set_sum = 0;
        set_closed = 1'b0;
        built_count = 0;
        start   <= 1'b0;
        in_word <= '0;
        rst_n   <= 1'b0;
        gap_pct = 12;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single entry, zero weight, mixed extremes, reads during a new load
        add_row(load_word(16'd5, 1'b1));
        add_row(read_word(0), 1'b1, lone_entry(32'h0001_0000, 5));
        add_row(load_word(16'd0, 1'b1));
        add_row(read_word(0), 1'b1, lone_entry(atb_pkg::Sat32, 0));
        add_row(load_word(16'hFFFF, 1'b0));
        add_row(load_word(16'd0, 1'b0));
        add_row(load_word(16'd1, 1'b0));
        add_row(load_word(16'hFFFF, 1'b1));
        for (int i = 0; i < 4; i++)
            add_row(read_word(i));
        add_row(load_word(16'd7, 1'b0));
        add_row(read_word(3));
        add_row(load_word(16'd9, 1'b1));
        add_row(read_word(0));
        add_row(read_word(1));
        add_row(load_word(16'd3, 1'b0));
        add_row(load_word(16'd3, 1'b0));
        add_row(load_word(16'd3, 1'b1));
        for (int i = 0; i < 3; i++)
            add_row(read_word(i));
        foreach (dir_rows[i])
            send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);

        // oversized set: loads past the table size are dropped, last still builds
        for (int i = 0; i < atb_pkg::MaxEntries + 6; i++)
            send_word(load_word(pick_weight(), i == atb_pkg::MaxEntries + 5), 1'b0, '0);
        send_word(read_word(atb_pkg::MaxEntries - 1), 1'b0, '0);
        for (int i = 0; i < 20; i++)
            send_word(read_word($urandom_range(atb_pkg::MaxEntries - 1)), 1'b0, '0);

        // random sets with reads, some interleaved with the loads
        while (sent_items < 1300)
        begin
            if (sent_items > 1220)
                gap_pct = 0;
            else if (sent_items > 1140)
                gap_pct = 82;
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_word(read_word($urandom_range(atb_pkg::MaxEntries - 1)), 1'b0, '0);
                send_word(load_word(pick_weight(), i == n - 1), 1'b0, '0);
            end
            repeat ($urandom_range(1, n + 2))
            begin
                idx = ($urandom_range(4) == 0) ? $urandom_range(atb_pkg::MaxEntries - 1)
                                               : $urandom_range(built_count - 1);
                send_word(read_word(idx), 1'b0, '0);
            end
        end
        start <= 1'b0;

        while (read_words_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
